/* rtl/core/ao0fm_pkg.sv */
// Shared types and constants for the adaptive order-zero frequency model.
// Used by ao0fm_div and adaptive_order0_freq_model_top; no dependencies.
package ao0fm_pkg;

    localparam int CODER_W    = 32;
    localparam int SYM_W      = 9;
    localparam int FREQ_CFG_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GUARD_W    = 6;
    localparam int HALVE_GUARD = 40;

    // command codes
    localparam logic [1:0] CMD_ENCODE     = 2'd0;
    localparam logic [1:0] CMD_DECODE     = 2'd1;
    localparam logic [1:0] CMD_ENCODE_EOF = 2'd2;
    localparam logic [1:0] CMD_REINIT     = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_NEW = 2'd1;
    localparam logic [1:0] STATUS_EOF = 2'd2;
    localparam logic [1:0] STATUS_ERR = 2'd3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_EOF_FREQ    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ESCAPE_FREQ = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_SYMS   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_FREQ   = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [SYM_W-1:0]   symbol;
        logic               use_subrange;
        logic [SYM_W-1:0]   range_first;
        logic [SYM_W-1:0]   range_last;
        logic [CODER_W-1:0] coder_low;
        logic [CODER_W-1:0] coder_range;
        logic [CODER_W-1:0] coder_value;
    } in_t;

    typedef struct packed {
        logic [CODER_W-1:0] new_low;
        logic               low_carry;
        logic [CODER_W-1:0] new_range;
        logic [SYM_W-1:0]   symbol_out;
        logic [1:0]         status;
    } out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RD_HI,
        ST_BASE,
        ST_RD_BASE,
        ST_TOT,
        ST_DIV_T,
        ST_DIV_Q,
        ST_SEARCH,
        ST_SEARCH_CMP,
        ST_NAR,
        ST_NAR_CUR,
        ST_NAR_BELOW,
        ST_MUL_LOW,
        ST_MUL_RANGE,
        ST_POST,
        ST_SWEEP,
        ST_SWEEP_END,
        ST_INSTALL,
        ST_BLD_START,
        ST_BLD_STEP,
        ST_BLD_CHK,
        ST_FINISH
    } state_t;

endpackage

/* rtl/core/ao0fm_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ao0fm_pkg for the coder word width.
module ao0fm_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ao0fm_pkg::CODER_W-1:0]  dividend,
    input  logic [ao0fm_pkg::CODER_W-1:0]  divisor,
    output logic [ao0fm_pkg::CODER_W-1:0]  quotient,
    output logic                           done
);

    localparam int W  = ao0fm_pkg::CODER_W;
    localparam int NW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  divr_reg, divr_next;
    logic [W:0]    shifted;
    logic [W+1:0]  diff;

    // one shift-subtract step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        divr_next = divr_reg;
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = {1'b0, shifted} - {2'b00, divr_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = NW'(W);
            rem_next  = '0;
            quo_next  = dividend;
            divr_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = diff[W+1] ? shifted[W-1:0] : diff[W-1:0];
            quo_next = {quo_reg[W-2:0], ~diff[W+1]};
            cnt_next = cnt_reg - NW'(1);
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            divr_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            divr_reg <= divr_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* rtl/core/adaptive_order0_freq_model_top.sv */
// Adaptive order-zero frequency model: table memory, sequencer and coder math.
// Depends on ao0fm_pkg and ao0fm_div.
//
//   channel  signals                          direction
//   in       in_valid / in_ready / in_data    request in
//   out      out_valid / out_ready / out_data result out
//   cfg      cfg_we / cfg_addr / cfg_wdata    register write, no wait
//
// One request at a time. Encode runs one division, then an increment sweep
// through the table memory port from the symbol upward; a subrange adds up
// to two table reads. Decode adds a second division and a binary search over
// the table. A halving pass adds another sweep over the whole table.
// Reinitialize and reset run a build pass that writes each installed symbol;
// in_ready stays low until it ends.
// A stalled result waits in the output register while the next request runs.
module adaptive_order0_freq_model_top #(
    parameter int MAX_SYMBOLS = 512,
    parameter int FREQ_BITS   = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  ao0fm_pkg::in_t                       in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output ao0fm_pkg::out_t                      out_data,
    input  logic                                 cfg_we,
    input  logic [ao0fm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ao0fm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int AW  = $clog2(MAX_SYMBOLS);
    localparam int CW  = $clog2(MAX_SYMBOLS + 1);
    localparam int SW  = ao0fm_pkg::SYM_W;
    localparam int FW  = ao0fm_pkg::FREQ_CFG_W;
    localparam int XW  = ao0fm_pkg::CODER_W;
    localparam int GW  = ao0fm_pkg::GUARD_W;
    localparam int EW  = ((CW + FW) > FREQ_BITS) ? (CW + FW) : FREQ_BITS;
    localparam int IW  = ((CW > SW) ? CW : SW) + 1;
    localparam int TW  = ((EW > XW) ? EW : XW) + 1;
    localparam logic [EW-1:0] TOTAL_LIMIT = EW'((64'd1 << (FREQ_BITS - 2)) - 64'd1);

    // table memory
    logic [EW-1:0] mem [MAX_SYMBOLS];
    logic [EW-1:0] mem_q;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [EW-1:0] mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q <= mem[mem_ra];
    end

    // configuration registers
    logic [FW-1:0] eof_freq_reg, esc_freq_reg, init_freq_reg;
    logic [SW-1:0] init_syms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eof_freq_reg  <= '0;
            esc_freq_reg  <= FW'(1);
            init_syms_reg <= '0;
            init_freq_reg <= FW'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ao0fm_pkg::CFG_EOF_FREQ:    eof_freq_reg  <= cfg_wdata;
                ao0fm_pkg::CFG_ESCAPE_FREQ: esc_freq_reg  <= cfg_wdata;
                ao0fm_pkg::CFG_INIT_SYMS:   init_syms_reg <= cfg_wdata[SW-1:0];
                ao0fm_pkg::CFG_INIT_FREQ:   init_freq_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // divider
    logic          div_start;
    logic [XW-1:0] div_a, div_b, div_q;
    logic          div_done;

    ao0fm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (div_q),
        .done     (div_done)
    );

    // sequencer registers
    ao0fm_pkg::state_t state_reg, state_next;
    ao0fm_pkg::in_t    in_reg, in_next;
    ao0fm_pkg::out_t   res_reg, res_next, out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [FW-1:0] bld_eof_reg, bld_eof_next, bld_esc_reg, bld_esc_next;
    logic [FW-1:0] bld_ifreq_reg, bld_ifreq_next;
    logic [SW-1:0] bld_nsym_reg, bld_nsym_next;
    logic          bld_cmd_reg, bld_cmd_next, in_build_reg, in_build_next;

    logic [CW-1:0] count_reg, count_next, n_inst_reg, n_inst_next;
    logic [EW-1:0] total_reg, total_next;
    logic          eof_on_reg, eof_on_next, esc_on_reg, esc_on_next;
    logic [GW-1:0] guard_reg, guard_next;

    logic [AW-1:0] lo_reg, lo_next, hi_reg, hi_next, idx_reg, idx_next;
    logic [AW-1:0] bs_l_reg, bs_l_next, bs_r_reg, bs_r_next, mid_reg, mid_next;
    logic [EW-1:0] cum_hi_reg, cum_hi_next, base_reg, base_next;
    logic [EW-1:0] cur_reg, cur_next, below_reg, below_next;
    logic [XW-1:0] t_reg, t_next, prod_reg, prod_next;
    logic [TW-1:0] target_reg, target_next;
    logic          is_esc_reg, is_esc_next;

    logic [CW-1:0] sw_ptr_reg, sw_ptr_next;
    logic          sw_v_reg, sw_v_next, sw_halve_reg, sw_halve_next;
    logic [AW-1:0] sw_addr_reg, sw_addr_next;
    logic [EW-1:0] sw_prev_reg, sw_prev_next, sw_acc_reg, sw_acc_next;

    // combinational helpers
    logic [1:0]      first_ord;
    logic [AW-1:0]   esc_idx;
    logic [IW-1:0]   rf_abs, rl_abs, sym_abs, cnt_w, max_w, bld_sum;
    logic            sub_on, full;
    logic [XW-1:0]   mul_b;
    logic [2*XW-1:0] mul_full;
    logic [XW:0]     low_sum;
    logic [EW-1:0]   tot, bld_f, halve_new;
    logic [EW:0]     halve_f;
    logic [AW:0]     mid_sum;
    logic [TW-1:0]   target_w;

    assign first_ord = 2'(eof_on_reg) + 2'(esc_on_reg);
    assign esc_idx   = eof_on_reg ? AW'(1) : '0;
    assign rf_abs    = IW'(in_reg.range_first) + IW'(first_ord);
    assign rl_abs    = IW'(in_reg.range_last) + IW'(first_ord);
    assign sym_abs   = IW'(in_reg.symbol) + IW'(first_ord);
    assign cnt_w     = IW'(count_reg);
    assign max_w     = IW'(MAX_SYMBOLS);
    assign full      = (cnt_w >= max_w);
    assign sub_on    = in_reg.use_subrange && (in_reg.cmd != ao0fm_pkg::CMD_ENCODE_EOF);
    assign tot       = cum_hi_reg - base_reg;
    assign mid_sum   = {1'b0, bs_l_reg} + {1'b0, bs_r_reg};
    assign target_w  = TW'(div_q) + TW'(base_reg);
    assign halve_f   = ({1'b0, mem_q} - {1'b0, sw_prev_reg} + (EW + 1)'(1)) >> 1;
    assign halve_new = sw_acc_reg + halve_f[EW-1:0];
    assign mul_full  = t_reg * mul_b;
    assign low_sum   = {1'b0, in_reg.coder_low} + {1'b0, prod_reg};
    assign bld_sum   = IW'(2'(bld_eof_reg != '0) + 2'(bld_esc_reg != '0)) + IW'(bld_nsym_reg);

    // build-pass frequency for the next installed entry
    always_comb
    begin
        if (count_reg == '0 && eof_on_reg)
        begin
            bld_f = EW'(bld_eof_reg);
        end
        else if (count_reg < CW'(first_ord))
        begin
            bld_f = EW'(bld_esc_reg);
        end
        else if (bld_ifreq_reg == '0)
        begin
            bld_f = EW'(1);
        end
        else
        begin
            bld_f = EW'(bld_ifreq_reg);
        end
    end

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        in_next        = in_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        bld_eof_next   = bld_eof_reg;
        bld_esc_next   = bld_esc_reg;
        bld_ifreq_next = bld_ifreq_reg;
        bld_nsym_next  = bld_nsym_reg;
        bld_cmd_next   = bld_cmd_reg;
        in_build_next  = in_build_reg;
        count_next     = count_reg;
        n_inst_next    = n_inst_reg;
        total_next     = total_reg;
        eof_on_next    = eof_on_reg;
        esc_on_next    = esc_on_reg;
        guard_next     = guard_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        bs_l_next      = bs_l_reg;
        bs_r_next      = bs_r_reg;
        mid_next       = mid_reg;
        cum_hi_next    = cum_hi_reg;
        base_next      = base_reg;
        cur_next       = cur_reg;
        below_next     = below_reg;
        t_next         = t_reg;
        prod_next      = prod_reg;
        target_next    = target_reg;
        is_esc_next    = is_esc_reg;
        sw_ptr_next    = sw_ptr_reg;
        sw_v_next      = sw_v_reg;
        sw_halve_next  = sw_halve_reg;
        sw_addr_next   = sw_addr_reg;
        sw_prev_next   = sw_prev_reg;
        sw_acc_next    = sw_acc_reg;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        mem_ra         = '0;
        div_start      = 1'b0;
        div_a          = in_reg.coder_range;
        div_b          = XW'(tot);
        mul_b          = XW'(below_reg - base_reg);
        in_ready       = 1'b0;

        case (state_reg)
            ao0fm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    in_next    = in_data;
                    state_next = ao0fm_pkg::ST_DISPATCH;
                end
            end

            // cheap checks, bounds of the coded slice
            ao0fm_pkg::ST_DISPATCH:
            begin
                res_next = '{new_low: in_reg.coder_low, low_carry: 1'b0,
                             new_range: in_reg.coder_range, symbol_out: '0,
                             status: ao0fm_pkg::STATUS_ERR};
                state_next  = ao0fm_pkg::ST_FINISH;
                is_esc_next = 1'b0;
                if (in_reg.cmd == ao0fm_pkg::CMD_REINIT)
                begin
                    res_next.status = ao0fm_pkg::STATUS_OK;
                    bld_eof_next    = eof_freq_reg;
                    bld_esc_next    = esc_freq_reg;
                    bld_ifreq_next  = init_freq_reg;
                    bld_nsym_next   = init_syms_reg;
                    bld_cmd_next    = 1'b1;
                    state_next      = ao0fm_pkg::ST_BLD_START;
                end
                else if (count_reg == '0)
                begin
                    state_next = ao0fm_pkg::ST_FINISH;
                end
                else if (sub_on && (in_reg.range_first > in_reg.range_last
                                    || rl_abs >= cnt_w))
                begin
                    state_next = ao0fm_pkg::ST_FINISH;
                end
                else if (sub_on && in_reg.range_first == in_reg.range_last)
                begin
                    if (in_reg.cmd == ao0fm_pkg::CMD_DECODE
                        || in_reg.symbol == in_reg.range_first)
                    begin
                        res_next.symbol_out = in_reg.range_first;
                        res_next.status     = ao0fm_pkg::STATUS_OK;
                    end
                end
                else if (in_reg.cmd == ao0fm_pkg::CMD_ENCODE_EOF && !eof_on_reg)
                begin
                    state_next = ao0fm_pkg::ST_FINISH;
                end
                else if (in_reg.cmd == ao0fm_pkg::CMD_ENCODE && sub_on
                         && (sym_abs < rf_abs || sym_abs > rl_abs))
                begin
                    state_next = ao0fm_pkg::ST_FINISH;
                end
                else if (in_reg.cmd == ao0fm_pkg::CMD_ENCODE && !sub_on && sym_abs >= cnt_w
                         && (sym_abs > cnt_w || !esc_on_reg || full))
                begin
                    state_next = ao0fm_pkg::ST_FINISH;
                end
                else
                begin
                    if (in_reg.cmd == ao0fm_pkg::CMD_ENCODE)
                    begin
                        if (!sub_on && sym_abs >= cnt_w)
                        begin
                            idx_next    = esc_idx;
                            is_esc_next = 1'b1;
                        end
                        else
                        begin
                            idx_next = sym_abs[AW-1:0];
                        end
                    end
                    else
                    begin
                        idx_next = '0;
                    end
                    if (sub_on)
                    begin
                        lo_next    = rf_abs[AW-1:0];
                        hi_next    = rl_abs[AW-1:0];
                        mem_ra     = rl_abs[AW-1:0];
                        state_next = ao0fm_pkg::ST_RD_HI;
                    end
                    else
                    begin
                        lo_next     = '0;
                        hi_next     = AW'(count_reg - CW'(1));
                        cum_hi_next = total_reg;
                        state_next  = ao0fm_pkg::ST_BASE;
                    end
                end
            end

            ao0fm_pkg::ST_RD_HI:
            begin
                cum_hi_next = mem_q;
                state_next  = ao0fm_pkg::ST_BASE;
            end

            ao0fm_pkg::ST_BASE:
            begin
                if (lo_reg != '0)
                begin
                    mem_ra     = lo_reg - AW'(1);
                    state_next = ao0fm_pkg::ST_RD_BASE;
                end
                else
                begin
                    base_next  = '0;
                    state_next = ao0fm_pkg::ST_TOT;
                end
            end

            ao0fm_pkg::ST_RD_BASE:
            begin
                base_next  = mem_q;
                state_next = ao0fm_pkg::ST_TOT;
            end

            // slice scale: range / total of the table or subrange
            ao0fm_pkg::ST_TOT:
            begin
                if (tot == '0)
                begin
                    state_next = ao0fm_pkg::ST_FINISH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ao0fm_pkg::ST_DIV_T;
                end
            end

            ao0fm_pkg::ST_DIV_T:
            begin
                div_a = in_reg.coder_value - in_reg.coder_low;
                div_b = div_q;
                if (div_done)
                begin
                    t_next = div_q;
                    if (div_q == '0)
                    begin
                        state_next = ao0fm_pkg::ST_FINISH;
                    end
                    else if (in_reg.cmd == ao0fm_pkg::CMD_DECODE)
                    begin
                        div_start  = 1'b1;
                        state_next = ao0fm_pkg::ST_DIV_Q;
                    end
                    else
                    begin
                        state_next = ao0fm_pkg::ST_NAR;
                    end
                end
            end

            // decode target and search bounds
            ao0fm_pkg::ST_DIV_Q:
            begin
                if (div_done)
                begin
                    target_next = target_w;
                    bs_l_next   = lo_reg;
                    bs_r_next   = hi_reg;
                    if (target_w >= TW'(cum_hi_reg))
                    begin
                        state_next = ao0fm_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = ao0fm_pkg::ST_SEARCH;
                    end
                end
            end

            ao0fm_pkg::ST_SEARCH:
            begin
                if (bs_r_reg > bs_l_reg)
                begin
                    mid_next   = mid_sum[AW:1];
                    mem_ra     = mid_sum[AW:1];
                    state_next = ao0fm_pkg::ST_SEARCH_CMP;
                end
                else
                begin
                    idx_next    = bs_r_reg;
                    is_esc_next = esc_on_reg && bs_r_reg == esc_idx;
                    if (esc_on_reg && bs_r_reg == esc_idx && full)
                    begin
                        state_next = ao0fm_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = ao0fm_pkg::ST_NAR;
                    end
                end
            end

            ao0fm_pkg::ST_SEARCH_CMP:
            begin
                if (TW'(mem_q) <= target_reg)
                begin
                    bs_l_next = mid_reg + AW'(1);
                end
                else
                begin
                    bs_r_next = mid_reg;
                end
                state_next = ao0fm_pkg::ST_SEARCH;
            end

            // fetch the symbol's slice bounds
            ao0fm_pkg::ST_NAR:
            begin
                mem_ra     = idx_reg;
                state_next = ao0fm_pkg::ST_NAR_CUR;
            end

            ao0fm_pkg::ST_NAR_CUR:
            begin
                cur_next = mem_q;
                if (idx_reg > lo_reg)
                begin
                    mem_ra     = idx_reg - AW'(1);
                    state_next = ao0fm_pkg::ST_NAR_BELOW;
                end
                else
                begin
                    below_next = base_reg;
                    state_next = ao0fm_pkg::ST_MUL_LOW;
                end
            end

            ao0fm_pkg::ST_NAR_BELOW:
            begin
                below_next = mem_q;
                state_next = ao0fm_pkg::ST_MUL_LOW;
            end

            // low offset product
            ao0fm_pkg::ST_MUL_LOW:
            begin
                mul_b      = XW'(below_reg - base_reg);
                prod_next  = mul_full[XW-1:0];
                state_next = ao0fm_pkg::ST_MUL_RANGE;
            end

            // new low, then slice width product
            ao0fm_pkg::ST_MUL_RANGE:
            begin
                res_next.new_low   = low_sum[XW-1:0];
                res_next.low_carry = low_sum[XW];
                mul_b              = XW'(cur_reg - below_reg);
                prod_next          = mul_full[XW-1:0];
                state_next         = ao0fm_pkg::ST_POST;
            end

            ao0fm_pkg::ST_POST:
            begin
                res_next.new_range = prod_reg;
                if (in_reg.cmd == ao0fm_pkg::CMD_ENCODE_EOF
                    || (in_reg.cmd == ao0fm_pkg::CMD_DECODE && eof_on_reg
                        && idx_reg == '0))
                begin
                    res_next.symbol_out = '0;
                    res_next.status     = ao0fm_pkg::STATUS_EOF;
                    state_next          = ao0fm_pkg::ST_FINISH;
                end
                else
                begin
                    if (in_reg.cmd == ao0fm_pkg::CMD_ENCODE)
                    begin
                        res_next.symbol_out = in_reg.symbol;
                    end
                    else if (is_esc_reg)
                    begin
                        res_next.symbol_out = SW'(cnt_w - IW'(first_ord));
                    end
                    else
                    begin
                        res_next.symbol_out = SW'(IW'(idx_reg) - IW'(first_ord));
                    end
                    res_next.status = is_esc_reg ? ao0fm_pkg::STATUS_NEW
                                                 : ao0fm_pkg::STATUS_OK;
                    // increment sweep from the coded symbol upward
                    total_next    = total_reg + EW'(1);
                    sw_ptr_next   = CW'(idx_reg);
                    sw_v_next     = 1'b0;
                    sw_halve_next = 1'b0;
                    state_next    = ao0fm_pkg::ST_SWEEP;
                end
            end

            // streaming read-modify-write over the table
            ao0fm_pkg::ST_SWEEP:
            begin
                if (sw_ptr_reg < count_reg)
                begin
                    mem_ra       = sw_ptr_reg[AW-1:0];
                    sw_addr_next = sw_ptr_reg[AW-1:0];
                    sw_ptr_next  = sw_ptr_reg + CW'(1);
                    sw_v_next    = 1'b1;
                end
                else
                begin
                    sw_v_next = 1'b0;
                    if (!sw_v_reg)
                    begin
                        state_next = ao0fm_pkg::ST_SWEEP_END;
                    end
                end
                if (sw_v_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = sw_addr_reg;
                    if (sw_halve_reg)
                    begin
                        mem_wd       = halve_new;
                        sw_acc_next  = halve_new;
                        sw_prev_next = mem_q;
                    end
                    else
                    begin
                        mem_wd = mem_q + EW'(1);
                    end
                end
            end

            ao0fm_pkg::ST_SWEEP_END:
            begin
                if (sw_halve_reg)
                begin
                    total_next = sw_acc_reg;
                    state_next = in_build_reg ? ao0fm_pkg::ST_BLD_CHK
                                              : ao0fm_pkg::ST_INSTALL;
                end
                else if (total_reg >= TOTAL_LIMIT)
                begin
                    sw_ptr_next   = '0;
                    sw_v_next     = 1'b0;
                    sw_halve_next = 1'b1;
                    sw_acc_next   = '0;
                    sw_prev_next  = '0;
                    state_next    = ao0fm_pkg::ST_SWEEP;
                end
                else
                begin
                    state_next = ao0fm_pkg::ST_INSTALL;
                end
            end

            // escape installs a new symbol with frequency one
            ao0fm_pkg::ST_INSTALL:
            begin
                if (is_esc_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = count_reg[AW-1:0];
                    mem_wd     = total_reg + EW'(1);
                    total_next = total_reg + EW'(1);
                    count_next = count_reg + CW'(1);
                end
                state_next = ao0fm_pkg::ST_FINISH;
            end

            ao0fm_pkg::ST_BLD_START:
            begin
                eof_on_next   = bld_eof_reg != '0;
                esc_on_next   = bld_esc_reg != '0;
                n_inst_next   = (bld_sum > max_w) ? CW'(MAX_SYMBOLS) : CW'(bld_sum);
                count_next    = '0;
                total_next    = '0;
                guard_next    = '0;
                in_build_next = 1'b1;
                state_next    = ao0fm_pkg::ST_BLD_STEP;
            end

            // one installed entry per cycle
            ao0fm_pkg::ST_BLD_STEP:
            begin
                if (count_reg < n_inst_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = count_reg[AW-1:0];
                    mem_wd     = total_reg + bld_f;
                    total_next = total_reg + bld_f;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    state_next = ao0fm_pkg::ST_BLD_CHK;
                end
            end

            // halve until the initial total is below the limit, at most HALVE_GUARD times
            ao0fm_pkg::ST_BLD_CHK:
            begin
                if (guard_reg < GW'(ao0fm_pkg::HALVE_GUARD) && count_reg != '0
                    && total_reg >= TOTAL_LIMIT)
                begin
                    guard_next    = guard_reg + GW'(1);
                    sw_ptr_next   = '0;
                    sw_v_next     = 1'b0;
                    sw_halve_next = 1'b1;
                    sw_acc_next   = '0;
                    sw_prev_next  = '0;
                    state_next    = ao0fm_pkg::ST_SWEEP;
                end
                else
                begin
                    in_build_next = 1'b0;
                    bld_cmd_next  = 1'b0;
                    state_next    = bld_cmd_reg ? ao0fm_pkg::ST_FINISH
                                                : ao0fm_pkg::ST_IDLE;
                end
            end

            ao0fm_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ao0fm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ao0fm_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ao0fm_pkg::ST_BLD_START;
            out_valid_reg <= 1'b0;
            bld_eof_reg   <= '0;
            bld_esc_reg   <= FW'(1);
            bld_ifreq_reg <= FW'(1);
            bld_nsym_reg  <= '0;
            bld_cmd_reg   <= 1'b0;
            in_build_reg  <= 1'b0;
            count_reg     <= '0;
            n_inst_reg    <= '0;
            total_reg     <= '0;
            eof_on_reg    <= 1'b0;
            esc_on_reg    <= 1'b0;
            guard_reg     <= '0;
            sw_ptr_reg    <= '0;
            sw_v_reg      <= 1'b0;
            sw_halve_reg  <= 1'b0;
            is_esc_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bld_eof_reg   <= bld_eof_next;
            bld_esc_reg   <= bld_esc_next;
            bld_ifreq_reg <= bld_ifreq_next;
            bld_nsym_reg  <= bld_nsym_next;
            bld_cmd_reg   <= bld_cmd_next;
            in_build_reg  <= in_build_next;
            count_reg     <= count_next;
            n_inst_reg    <= n_inst_next;
            total_reg     <= total_next;
            eof_on_reg    <= eof_on_next;
            esc_on_reg    <= esc_on_next;
            guard_reg     <= guard_next;
            sw_ptr_reg    <= sw_ptr_next;
            sw_v_reg      <= sw_v_next;
            sw_halve_reg  <= sw_halve_next;
            is_esc_reg    <= is_esc_next;
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        in_reg      <= in_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        idx_reg     <= idx_next;
        bs_l_reg    <= bs_l_next;
        bs_r_reg    <= bs_r_next;
        mid_reg     <= mid_next;
        cum_hi_reg  <= cum_hi_next;
        base_reg    <= base_next;
        cur_reg     <= cur_next;
        below_reg   <= below_next;
        t_reg       <= t_next;
        prod_reg    <= prod_next;
        target_reg  <= target_next;
        sw_addr_reg <= sw_addr_next;
        sw_prev_reg <= sw_prev_next;
        sw_acc_reg  <= sw_acc_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
